FILE: hw/rtl/idhu_pkg.sv
package idhu_pkg;

    typedef enum logic [2:0] {
        OP_COPYSIGN  = 3'd0,
        OP_CLASSIFY  = 3'd1,
        OP_ILOGB     = 3'd2,
        OP_NEXTAFTER = 3'd3,
        OP_SCALBN    = 3'd4
    } op_t;

    localparam logic [63:0] SIGN_MASK  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] EXP_MASK   = 64'h7ff0_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT  = 64'h0008_0000_0000_0000;
    localparam logic [31:0] ILOGB_ZERO = 32'h8000_0001;
    localparam logic [31:0] ILOGB_INF  = 32'h7fff_ffff;
    localparam logic [10:0] EXP_ALL1   = 11'h7ff;
    localparam int          SCALE_LIMIT    = 5000;
    localparam int          EXP_MAX_FINITE = 'h7fe;
    localparam int          UNDER_CUT      = -54;

    // result word fields
    typedef struct packed {
        logic [63:0] value_bits;
        logic [31:0] int_value;
        logic        is_finite;
        logic        is_infinite;
        logic        is_nan;
        logic        is_normal;
        logic        is_subnormal;
        logic        is_zero;
        logic        sign_bit;
        logic        overflow_flag;
        logic        underflow_flag;
        logic        inexact_flag;
    } res_t;

    // leading one position of a 52-bit fraction (0 when empty)
    function automatic logic [5:0] lead_one(input logic [51:0] v);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 52; i++) begin
            if (v[i]) p = 6'(i);
        end
        return p;
    endfunction

endpackage

FILE: hw/rtl/ieee_double_helper_unit_top.sv
// IEEE-754 double helper unit: copysign, classify, ilogb, nextafter, scalbn.
// Input channel s_axis: one word per operation, accepted when s_tvalid and
// s_tready are both high. Output channel m_axis: one result word per input
// word, in order.
// Pipeline: three register stages (decode/leading-one search, per-operation
// work, rounding and flags); an accepted word passes through all three
// registers before its result shows on m_tvalid and m_tdata.
// Throughput: one word per cycle while m_tready stays high; every stage
// takes a new word each cycle.
// Stall: when m_tready is low with a valid result, the whole pipeline holds
// and s_tready drops; bubbles inside the pipe are not squeezed out.
// Reset (aresetn low, synchronous) empties the pipeline; no words are lost
// or repeated across a stall.
module ieee_double_helper_unit_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [2:0] operation, [66:3] x_bits, [130:67] y_bits, [162:131] shift_count
    input  logic [167:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [63:0] value_bits, [95:64] int_value, [96] is_finite, [97] is_infinite,
    // [98] is_nan, [99] is_normal, [100] is_subnormal, [101] is_zero,
    // [102] sign_bit, [103] overflow_flag, [104] underflow_flag,
    // [105] inexact_flag
    output logic [111:0] m_tdata
);
    import idhu_pkg::*;

    logic adv;
    res_t res;

    // advance when the output slot is free or being taken
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    idhu_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_op     (s_tdata[2:0]),
        .in_x      (s_tdata[66:3]),
        .in_y      (s_tdata[130:67]),
        .in_n      (s_tdata[162:131]),
        .adv       (adv),
        .out_valid (m_tvalid),
        .out_res   (res)
    );

    assign m_tdata = {6'd0, res.inexact_flag, res.underflow_flag, res.overflow_flag,
                      res.sign_bit, res.is_zero, res.is_subnormal, res.is_normal,
                      res.is_nan, res.is_infinite, res.is_finite,
                      res.int_value, res.value_bits};
endmodule

FILE: hw/rtl/idhu_core.sv
module idhu_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic [2:0]          in_op,
    input  logic [63:0]         in_x,
    input  logic [63:0]         in_y,
    input  logic signed [31:0]  in_n,
    input  logic                adv,       // pipeline advance
    output logic                out_valid,
    output idhu_pkg::res_t      out_res
);
    import idhu_pkg::*;

    // ---------------- stage 1: decode, normalize ----------------
    logic        v1_reg;
    logic [2:0]  op1_reg;
    logic [63:0] x1_reg, y1_reg;
    logic signed [31:0] n1_reg;
    logic [5:0]  p1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
        end
        if (adv) begin
            op1_reg <= in_op;
            x1_reg  <= in_x;
            y1_reg  <= in_y;
            n1_reg  <= in_n;
            p1_reg  <= lead_one(in_x[51:0]);
        end
    end

    // ---------------- stage 2: per-op main work ----------------
    logic [10:0] e1;
    logic [51:0] f1;
    logic        s1;
    assign e1 = x1_reg[62:52];
    assign f1 = x1_reg[51:0];
    assign s1 = x1_reg[63];

    logic        x_nan1, y_nan1;
    assign x_nan1 = (e1 == EXP_ALL1) && (f1 != '0);
    assign y_nan1 = (y1_reg[62:52] == EXP_ALL1) && (y1_reg[51:0] != '0);

    // nextafter step
    logic [63:0] kx, ky, na_val;
    logic        dec, na_chk;
    always_comb begin
        kx = s1 ? ~x1_reg : (x1_reg | SIGN_MASK);
        ky = y1_reg[63] ? ~y1_reg : (y1_reg | SIGN_MASK);
        dec = s1 ? (ky > kx) : (ky < kx);
        na_chk = 1'b0;
        if (x_nan1) na_val = x1_reg | QUIET_BIT;
        else if (y_nan1) na_val = y1_reg | QUIET_BIT;
        else if (x1_reg == y1_reg || ((x1_reg | y1_reg) & ~SIGN_MASK) == '0) na_val = x1_reg;
        else if (x1_reg[62:0] == '0) begin
            na_val = (y1_reg & SIGN_MASK) | 64'd1;
            na_chk = 1'b1;
        end else begin
            na_val = dec ? x1_reg - 64'd1 : x1_reg + 64'd1;
            na_chk = 1'b1;
        end
    end

    // scalbn exponent and normalized significand
    logic [52:0] m1;
    logic signed [33:0] k1;
    always_comb begin
        if (e1 == '0) begin
            m1 = 53'({1'b0, f1} << (6'd52 - p1_reg));
            k1 = 34'(signed'({1'b0, p1_reg})) - 34'sd51 + 34'(n1_reg);
        end else begin
            m1 = {1'b1, f1};
            k1 = 34'(signed'({1'b0, e1})) + 34'(n1_reg);
        end
    end

    typedef enum logic [2:0] {SC_PASS, SC_OVF, SC_UNF, SC_NORM, SC_SUB} sc_t;
    sc_t sc1;
    logic [63:0] pass1;
    always_comb begin
        pass1 = x1_reg;
        if (e1 == EXP_ALL1) begin
            sc1 = SC_PASS;
            if (x_nan1) pass1 = x1_reg | QUIET_BIT;
        end else if (x1_reg[62:0] == '0) sc1 = SC_PASS;
        else if (n1_reg > 32'(SCALE_LIMIT) || k1 > 34'(EXP_MAX_FINITE)) sc1 = SC_OVF;
        else if (n1_reg < -32'(SCALE_LIMIT) || k1 <= 34'(UNDER_CUT)) sc1 = SC_UNF;
        else if (k1 > 34'sd0) sc1 = SC_NORM;
        else sc1 = SC_SUB;
    end

    logic [31:0] ilogb1;
    always_comb begin
        if (e1 == EXP_ALL1) ilogb1 = ILOGB_INF;
        else if (e1 != '0) ilogb1 = 32'({21'd0, e1}) - 32'd1023;
        else if (f1 == '0) ilogb1 = ILOGB_ZERO;
        else ilogb1 = 32'({26'd0, p1_reg}) - 32'd1074;
    end

    logic        v2_reg, na_chk2_reg;
    logic [2:0]  op2_reg;
    logic [63:0] x2_reg, val2_reg;
    logic [31:0] ival2_reg;
    logic [52:0] m2_reg;
    logic [10:0] k2_reg;   // normal exponent (low bits of k1)
    logic [5:0]  sh2_reg;  // 1..54
    sc_t         sc2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
        if (adv) begin
            op2_reg     <= op1_reg;
            x2_reg      <= x1_reg;
            ival2_reg   <= (op1_reg == OP_ILOGB) ? ilogb1 : '0;
            m2_reg      <= m1;
            k2_reg      <= k1[10:0];
            sh2_reg     <= 6'(34'sd1 - k1);
            sc2_reg     <= sc1;
            na_chk2_reg <= na_chk;
            case (op1_reg)
                OP_COPYSIGN:  val2_reg <= (x1_reg & ~SIGN_MASK) | (y1_reg & SIGN_MASK);
                OP_NEXTAFTER: val2_reg <= na_val;
                OP_SCALBN:    val2_reg <= pass1;
                default:      val2_reg <= '0;
            endcase
        end
    end

    // ---------------- stage 3: round, flags, classify ----------------
    // one spare bit so a shift of 54 keeps the half-way point
    logic [63:0] sign3;
    logic [53:0] q3, rem3, half3, mask3;
    logic [53:0] qr3;
    logic        rup3;
    res_t        r3;
    always_comb begin
        sign3 = x2_reg & SIGN_MASK;
        mask3 = ~(54'h3f_ffff_ffff_ffff << sh2_reg);
        q3    = {1'b0, m2_reg} >> sh2_reg;
        rem3  = {1'b0, m2_reg} & mask3;
        half3 = 54'd1 << (sh2_reg - 6'd1);
        rup3  = (rem3 > half3) || (rem3 == half3 && q3[0]);
        qr3   = q3 + 54'(rup3);

        r3 = '0;
        r3.int_value    = ival2_reg;
        r3.is_finite    = x2_reg[62:52] != EXP_ALL1;
        r3.is_infinite  = x2_reg[62:52] == EXP_ALL1 && x2_reg[51:0] == '0;
        r3.is_nan       = x2_reg[62:52] == EXP_ALL1 && x2_reg[51:0] != '0;
        r3.is_normal    = x2_reg[62:52] != '0 && x2_reg[62:52] != EXP_ALL1;
        r3.is_subnormal = x2_reg[62:52] == '0 && x2_reg[51:0] != '0;
        r3.is_zero      = x2_reg[62:0] == '0;
        r3.sign_bit     = x2_reg[63];
        r3.value_bits   = val2_reg;
        if (op2_reg == OP_NEXTAFTER && na_chk2_reg) begin
            r3.overflow_flag  = val2_reg[62:52] == EXP_ALL1;
            r3.underflow_flag = val2_reg[62:52] == '0;
            r3.inexact_flag   = r3.overflow_flag | r3.underflow_flag;
        end else if (op2_reg == OP_SCALBN) begin
            case (sc2_reg)
                SC_OVF: begin
                    r3.value_bits    = sign3 | EXP_MASK;
                    r3.overflow_flag = 1'b1;
                    r3.inexact_flag  = 1'b1;
                end
                SC_UNF: begin
                    r3.value_bits     = sign3;
                    r3.underflow_flag = 1'b1;
                    r3.inexact_flag   = 1'b1;
                end
                SC_NORM: r3.value_bits = sign3 | {1'b0, k2_reg, m2_reg[51:0]};
                SC_SUB: begin
                    r3.value_bits     = sign3 | {10'd0, qr3};
                    r3.inexact_flag   = rem3 != '0;
                    r3.underflow_flag = !qr3[52];
                end
                default: ;
            endcase
        end
    end

    logic v3_reg;
    res_t r3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
        if (adv) r3_reg <= r3;
    end

    assign out_valid = v3_reg;
    assign out_res   = r3_reg;
endmodule

FILE: dv/testbench.sv
module testbench;
    import idhu_pkg::*;

    typedef struct {
        logic [2:0]  opcode;
        logic [63:0] x;
        logic [63:0] y;
        logic [31:0] shift;
    } op_word_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // [2:0] operation, [66:3] x_bits, [130:67] y_bits, [162:131] shift_count
    logic [167:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // [63:0] value_bits, [95:64] int_value, [96] is_finite ... [105] inexact_flag
    logic [111:0] m_tdata;

    op_word_t pending_ops[$];
    res_t     expected_results[$];
    int       error_count;
    int       cycle_count;
    bit       hold_sender;
    bit       idle_free;

    localparam int CYCLE_LIMIT = 200000;

    ieee_double_helper_unit_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // highest set bit of a nonzero value
    function automatic int msb_pos(input logic [63:0] v);
        int p;
        p = 0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) p = i;
        end
        return p;
    endfunction

    function automatic bit nan_bits(input logic [63:0] b);
        return b[62:52] == EXP_ALL1 && b[51:0] != 0;
    endfunction

    // numeric order of non-NaN doubles as unsigned order
    function automatic logic [63:0] order_of(input logic [63:0] b);
        return b[63] ? ~b : (b | SIGN_MASK);
    endfunction

    function automatic res_t predict_double_op(input op_word_t w);
        res_t r;
        logic [10:0] e;
        logic [51:0] fr;
        logic [63:0] m, q, rem, half, sgn, rr;
        longint k, n;
        int s;
        bit dn;
        r = '0;
        e = w.x[62:52];
        fr = w.x[51:0];
        n = longint'($signed(w.shift));
        case (w.opcode)
            OP_COPYSIGN: r.value_bits = {w.y[63], w.x[62:0]};
            OP_ILOGB: begin
                if (e == EXP_ALL1) r.int_value = ILOGB_INF;
                else if (e != 0) r.int_value = 32'(int'(e) - 1023);
                else if (fr == 0) r.int_value = ILOGB_ZERO;
                else r.int_value = 32'(msb_pos({12'd0, fr}) - 1074);
            end
            OP_NEXTAFTER: begin
                if (nan_bits(w.x)) r.value_bits = w.x | QUIET_BIT;
                else if (nan_bits(w.y)) r.value_bits = w.y | QUIET_BIT;
                else if (w.x == w.y || ((w.x | w.y) & ~SIGN_MASK) == 0) r.value_bits = w.x;
                else begin
                    if ((w.x & ~SIGN_MASK) == 0) rr = (w.y & SIGN_MASK) | 64'd1;
                    else begin
                        dn = w.x[63] ? (order_of(w.y) > order_of(w.x))
                                     : (order_of(w.y) < order_of(w.x));
                        rr = dn ? w.x - 64'd1 : w.x + 64'd1;
                    end
                    r.value_bits = rr;
                    if (rr[62:52] == EXP_ALL1) r.overflow_flag = 1'b1;
                    else if (rr[62:52] == 0) r.underflow_flag = 1'b1;
                    r.inexact_flag = r.overflow_flag | r.underflow_flag;
                end
            end
            OP_SCALBN: begin
                sgn = w.x & SIGN_MASK;
                if (e == EXP_ALL1) r.value_bits = nan_bits(w.x) ? (w.x | QUIET_BIT) : w.x;
                else if ((w.x & ~SIGN_MASK) == 0) r.value_bits = w.x;
                else begin
                    if (e == 0) begin
                        s = msb_pos({12'd0, fr});
                        m = {12'd0, fr} << (52 - s);
                        k = longint'(s) - 51;
                    end else begin
                        m = {11'd1, fr};
                        k = longint'(e);
                    end
                    k += n;
                    if (n > SCALE_LIMIT || k > EXP_MAX_FINITE) begin
                        r.overflow_flag = 1'b1;
                        r.inexact_flag = 1'b1;
                        r.value_bits = sgn | EXP_MASK;
                    end else if (n < -SCALE_LIMIT || k <= UNDER_CUT) begin
                        r.underflow_flag = 1'b1;
                        r.inexact_flag = 1'b1;
                        r.value_bits = sgn;
                    end else if (k > 0) begin
                        r.value_bits = sgn | (64'(k) << 52) | {12'd0, m[51:0]};
                    end else begin
                        // subnormal: shift right, round to nearest even
                        s = int'(1 - k);
                        q = m >> s;
                        rem = m & ((64'd1 << s) - 64'd1);
                        half = 64'd1 << (s - 1);
                        if (rem > half || (rem == half && q[0])) q++;
                        r.inexact_flag = rem != 0;
                        r.underflow_flag = q[62:52] == 0;
                        r.value_bits = sgn | q;
                    end
                end
            end
            default: ;
        endcase
        r.is_finite = e != EXP_ALL1;
        r.is_infinite = e == EXP_ALL1 && fr == 0;
        r.is_nan = e == EXP_ALL1 && fr != 0;
        r.is_normal = e != 0 && e != EXP_ALL1;
        r.is_subnormal = e == 0 && fr != 0;
        r.is_zero = e == 0 && fr == 0;
        r.sign_bit = w.x[63];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    // random double biased toward interesting exponents and sparse fractions
    function automatic logic [63:0] rand_double();
        logic [63:0] b;
        b = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: b[62:52] = 11'd0;
            1: b[62:52] = EXP_ALL1;
            2: b[62:52] = 11'($urandom_range(1, 3));
            3: b[62:52] = 11'($urandom_range(2040, 2046));
            4: b[51:0] = $urandom_range(0, 1) ? 52'd0 : 52'(1) << $urandom_range(0, 51);
            default: ;
        endcase
        return b;
    endfunction

    function automatic logic [31:0] rand_shift();
        case ($urandom_range(0, 5))
            0: return {$urandom};
            1: return 32'($urandom_range(0, 10000)) - 32'd5000;
            2: return 32'($urandom_range(0, 12)) + 32'd4995;
            3: return -(32'($urandom_range(0, 12)) + 32'd4995);
            default: return 32'($urandom_range(0, 2200)) - 32'd1100;
        endcase
    endfunction

    task automatic push_op(input logic [2:0] opc, input logic [63:0] x,
                           input logic [63:0] y, input logic [31:0] sh);
        op_word_t w;
        w.opcode = opc;
        w.x = x;
        w.y = y;
        w.shift = sh;
        pending_ops.push_back(w);
    endtask

    // driver
    always @(posedge aclk) begin
        op_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_ops.size() != 0 && !hold_sender &&
                (idle_free || $urandom_range(0, 99) >= 20)) begin
                w = pending_ops.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {5'd0, w.shift, w.y, w.x, w.opcode};
                expected_results.push_back(predict_double_op(w));
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        res_t got, want;
        if (aresetn) begin
            m_tready <= idle_free || $urandom_range(0, 99) >= 20;
            if (m_tvalid && m_tready) begin
                got = '0;
                got.value_bits     = m_tdata[63:0];
                got.int_value      = m_tdata[95:64];
                got.is_finite      = m_tdata[96];
                got.is_infinite    = m_tdata[97];
                got.is_nan         = m_tdata[98];
                got.is_normal      = m_tdata[99];
                got.is_subnormal   = m_tdata[100];
                got.is_zero        = m_tdata[101];
                got.sign_bit       = m_tdata[102];
                got.overflow_flag  = m_tdata[103];
                got.underflow_flag = m_tdata[104];
                got.inexact_flag   = m_tdata[105];
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected word", got.value_bits, 64'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.value_bits !== want.value_bits)
                        report_mismatch("value_bits", got.value_bits, want.value_bits);
                    if (got.int_value !== want.int_value)
                        report_mismatch("int_value", 64'(got.int_value), 64'(want.int_value));
                    if (got[9:0] !== want[9:0])
                        report_mismatch("flags", 64'(got[9:0]), 64'(want[9:0]));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        logic [63:0] vals[12];
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        error_count = 0;
        cycle_count = 0;
        hold_sender = 1'b0;
        idle_free = 1'b0;
        vals = '{64'h0, SIGN_MASK, 64'h1, 64'h000f_ffff_ffff_ffff, 64'h0010_0000_0000_0000,
                 64'h7fef_ffff_ffff_ffff, EXP_MASK, SIGN_MASK | EXP_MASK,
                 64'h7ff0_0000_0000_0001, 64'hfff8_0000_0000_0000, 64'h3ff0_0000_0000_0000,
                 64'hffff_ffff_ffff_ffff};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: edges of each operation
        for (int i = 0; i < 12; i++) push_op(3'(i % 8), vals[i], vals[11 - i], 32'd1);
        push_op(OP_NEXTAFTER, SIGN_MASK, 64'd0, 32'd0);
        push_op(OP_NEXTAFTER, 64'd0, SIGN_MASK | 64'd5, 32'd0);
        push_op(OP_NEXTAFTER, 64'h7fef_ffff_ffff_ffff, EXP_MASK, 32'd0);
        push_op(OP_NEXTAFTER, 64'h0010_0000_0000_0000, 64'd0, 32'd0);
        push_op(OP_SCALBN, 64'h3ff0_0000_0000_0000, 64'd5001, 32'd5001);
        push_op(OP_SCALBN, 64'h3ff0_0000_0000_0000, 64'd0, -32'd5001);
        push_op(OP_SCALBN, 64'h3ff8_0000_0000_0000, 64'd0, -32'd1074);
        push_op(OP_SCALBN, 64'h3ff0_0000_0000_0000, 64'd0, -32'd1075);
        push_op(OP_SCALBN, 64'h3fff_ffff_ffff_ffff, 64'd0, -32'd1076);
        push_op(OP_SCALBN, 64'h000f_ffff_ffff_ffff, 64'd0, 32'd1);
        push_op(OP_SCALBN, 64'h001f_ffff_ffff_ffff, 64'd0, -32'd1);
        push_op(OP_SCALBN, 64'h7fe0_0000_0000_0000, 64'd0, 32'h8000_0000);
        push_op(OP_SCALBN, 64'h0000_0000_0000_0001, 64'd0, 32'h7fff_ffff);
        push_op(OP_ILOGB, 64'h0000_0000_0000_0001, 64'd0, 32'd0);
        while (pending_ops.size() != 0 || expected_results.size() != 0) @(posedge aclk);

        // random: first a stretch with no idling, then with idling
        idle_free = 1'b1;
        for (int i = 0; i < 550; i++) begin
            logic [63:0] x;
            x = rand_double();
            push_op($urandom_range(0, 9) == 0 ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4)),
                    x, $urandom_range(0, 3) == 0 ? x ^ 64'($urandom_range(0, 1)) << 63
                                                 : rand_double(),
                    rand_shift());
            if (i == 120) begin
                while (pending_ops.size() != 0) @(posedge aclk);
                idle_free = 1'b0;
            end
            if (i == 300) begin
                // drain the pipe fully before resuming
                while (pending_ops.size() != 0) @(posedge aclk);
                hold_sender = 1'b1;
                while (expected_results.size() != 0) @(posedge aclk);
                hold_sender = 1'b0;
            end
        end
        while (pending_ops.size() != 0 || expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule
